// ===== src/ttb_pkg.sv =====
// shared types and constants for the triangle tangent and bitangent pipeline
`default_nettype none
package ttb_pkg;

  // bit length that each vector's largest magnitude is scaled to
  localparam int NORM_BITS = 30;
  // unit length in q1.14
  localparam int ONE_Q14   = 16384;
  // width of the floor square root of a sum of three 60-bit squares
  localparam int ROOT_BITS = 31;
  // width of the quotient of one normalized component
  localparam int QUO_BITS  = 16;
  // width of the division remainder
  localparam int REM_BITS  = 47;
  // width of one packed output component
  localparam int OUT_BITS  = 16;

  typedef logic [NORM_BITS-1:0]   nmag_t;
  typedef logic [2*NORM_BITS-1:0] sq_t;
  typedef logic [ROOT_BITS-1:0]   root_t;
  typedef logic [REM_BITS-1:0]    drem_t;
  typedef logic [QUO_BITS-1:0]    quo_t;

  // control that travels with every word down the pipeline
  typedef struct packed {
    logic vld;
    logic tag;
  } ttb_ctl_t;

endpackage
`default_nettype wire

// ===== src/triangle_tangent_bitangent.sv =====
// top level: per-triangle tangent and bitangent unit vectors
//
// one triangle word enters when start is high and busy is low; busy stays low,
// so a new triangle may enter on every clock. each word carries three vertex
// positions (x,y,z) and three texture coordinates (u,v), components signed and
// COORD_BITS wide, packed from the low bits up.
// results leave in order, one per triangle, on tangent_vec, bitangent_vec and
// degenerate, marked by done for exactly one cycle; the receiver cannot stall.
// registered stages form edge deltas, products and signed magnitudes, and each
// vector then passes a 53-stage normalizer whose length is set by the 31-stage
// floor square root and the 16-stage restoring divider; a final register
// drives done and the result ports.
// throughput is one triangle per cycle.
// degenerate is high with both vectors zero when the uv determinant is zero or
// either vector is zero.
// synchronous reset clears every valid bit; words in flight are dropped.
`default_nettype none
module triangle_tangent_bitangent #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [47:0] pos_a,
  input  wire logic [47:0] pos_b,
  input  wire logic [47:0] pos_c,
  input  wire logic [31:0] tex_a,
  input  wire logic [31:0] tex_b,
  input  wire logic [31:0] tex_c,
  output logic             done,
  output logic [47:0]      tangent_vec,
  output logic [47:0]      bitangent_vec,
  output logic             degenerate
);
  import ttb_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PRE = (CB > NORM_BITS) ? CB - NORM_BITS : 0;
  localparam int DW  = CB - PRE + 1;
  localparam int MW  = 2 * DW;

  assign busy = 1'b0;

  // component extraction; bits above a field read as zero
  logic [3*CB+47:0] pa_x, pb_x, pc_x;
  logic [2*CB+31:0] ta_x, tb_x, tc_x;
  assign pa_x = {{(3*CB){1'b0}}, pos_a};
  assign pb_x = {{(3*CB){1'b0}}, pos_b};
  assign pc_x = {{(3*CB){1'b0}}, pos_c};
  assign ta_x = {{(2*CB){1'b0}}, tex_a};
  assign tb_x = {{(2*CB){1'b0}}, tex_b};
  assign tc_x = {{(2*CB){1'b0}}, tex_c};

  function automatic logic signed [DW-1:0] delta(input logic [CB-1:0] hi,
                                                 input logic [CB-1:0] lo);
    logic signed [CB:0] d;
    d = (CB+1)'($signed(hi)) - (CB+1)'($signed(lo));
    d = d >>> PRE;
    return d[DW-1:0];
  endfunction

  // stage 1: edges and uv deltas
  logic                     s1_vld;
  logic signed [DW-1:0]     s1_e1 [3];
  logic signed [DW-1:0]     s1_e2 [3];
  logic signed [DW-1:0]     s1_du1, s1_du2, s1_dv1, s1_dv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
    for (int k = 0; k < 3; k++) begin
      s1_e1[k] <= delta(pb_x[k*CB +: CB], pa_x[k*CB +: CB]);
      s1_e2[k] <= delta(pc_x[k*CB +: CB], pb_x[k*CB +: CB]);
    end
    s1_du1 <= delta(tb_x[0 +: CB], ta_x[0 +: CB]);
    s1_du2 <= delta(tc_x[0 +: CB], tb_x[0 +: CB]);
    s1_dv1 <= delta(tb_x[CB +: CB], ta_x[CB +: CB]);
    s1_dv2 <= delta(tc_x[CB +: CB], tb_x[CB +: CB]);
  end

  // stage 2: products
  logic                    s2_vld;
  logic signed [MW-1:0]    s2_pt1 [3];
  logic signed [MW-1:0]    s2_pt2 [3];
  logic signed [MW-1:0]    s2_pb1 [3];
  logic signed [MW-1:0]    s2_pb2 [3];
  logic signed [MW-1:0]    s2_pd1, s2_pd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    for (int k = 0; k < 3; k++) begin
      s2_pt1[k] <= s1_e1[k] * s1_dv2;
      s2_pt2[k] <= s1_e2[k] * s1_dv1;
      s2_pb1[k] <= s1_e2[k] * s1_du1;
      s2_pb2[k] <= s1_e1[k] * s1_du2;
    end
    s2_pd1 <= s1_du1 * s1_dv2;
    s2_pd2 <= s1_dv1 * s1_du2;
  end

  // stage 3: differences, determinant sign folded into magnitude and sign
  logic signed [MW:0]  tv [3];
  logic signed [MW:0]  bv [3];
  logic signed [MW:0]  det;
  logic [2:0][MW-1:0]  tmag_next, bmag_next;
  logic [2:0]          tneg_next, bneg_next;

  always_comb begin
    det = (MW+1)'(s2_pd1) - (MW+1)'(s2_pd2);
    for (int k = 0; k < 3; k++) begin
      tv[k] = (MW+1)'(s2_pt1[k]) - (MW+1)'(s2_pt2[k]);
      bv[k] = (MW+1)'(s2_pb1[k]) - (MW+1)'(s2_pb2[k]);
      tmag_next[k] = tv[k][MW] ? MW'(-tv[k]) : MW'(tv[k]);
      bmag_next[k] = bv[k][MW] ? MW'(-bv[k]) : MW'(bv[k]);
      tneg_next[k] = tv[k][MW] ^ det[MW];
      bneg_next[k] = bv[k][MW] ^ det[MW];
    end
  end

  ttb_ctl_t           s3_ctl;
  logic [2:0][MW-1:0] s3_tmag, s3_bmag;
  logic [2:0]         s3_tneg, s3_bneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.vld <= 1'b0;
    end else begin
      s3_ctl.vld <= s2_vld;
    end
    s3_ctl.tag <= (det == '0);
    s3_tmag    <= tmag_next;
    s3_bmag    <= bmag_next;
    s3_tneg    <= tneg_next;
    s3_bneg    <= bneg_next;
  end

  // normalizers
  ttb_ctl_t    t_ctl, b_ctl;
  logic [47:0] t_vec, b_vec;
  logic        t_ok, b_ok;

  ttb_unit #(.MW(MW)) u_tan (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (s3_ctl),
    .in_mag  (s3_tmag),
    .in_neg  (s3_tneg),
    .out_ctl (t_ctl),
    .out_vec (t_vec),
    .out_ok  (t_ok)
  );

  ttb_unit #(.MW(MW)) u_bit (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (s3_ctl),
    .in_mag  (s3_bmag),
    .in_neg  (s3_bneg),
    .out_ctl (b_ctl),
    .out_vec (b_vec),
    .out_ok  (b_ok)
  );

  // output word
  logic deg_next;
  assign deg_next = t_ctl.tag | b_ctl.tag | ~t_ok | ~b_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_ctl.vld & b_ctl.vld;
    end
    degenerate    <= deg_next;
    tangent_vec   <= deg_next ? '0 : t_vec;
    bitangent_vec <= deg_next ? '0 : b_vec;
  end

endmodule
`default_nettype wire

// ===== src/ttb_unit.sv =====
// pipelined normalization of one signed vector to a packed q1.14 unit vector
`default_nettype none
module ttb_unit #(
  parameter int MW = 34
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ttb_pkg::ttb_ctl_t   in_ctl,
  input  wire logic [2:0][MW-1:0]  in_mag,
  input  wire logic [2:0]          in_neg,
  output ttb_pkg::ttb_ctl_t        out_ctl,
  output logic [47:0]              out_vec,
  output logic                     out_ok
);
  import ttb_pkg::*;

  localparam int BLW = $clog2(MW + 1);
  localparam int SQS = ROOT_BITS;
  localparam int DVS = QUO_BITS;

  // stage a: bit length of the largest magnitude
  logic [MW-1:0]       or_all;
  logic [BLW-1:0]      bl_next;
  ttb_ctl_t            a_ctl;
  logic [2:0][MW-1:0]  a_mag;
  logic [2:0]          a_neg;
  logic [BLW-1:0]      a_bl;
  logic                a_ok;

  always_comb begin
    or_all  = in_mag[0] | in_mag[1] | in_mag[2];
    bl_next = '0;
    for (int j = 0; j < MW; j++) begin
      if (or_all[j]) begin
        bl_next = BLW'(j + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl.vld <= 1'b0;
    end else begin
      a_ctl.vld <= in_ctl.vld;
    end
    a_ctl.tag <= in_ctl.tag;
    a_mag     <= in_mag;
    a_neg     <= in_neg;
    a_bl      <= bl_next;
    a_ok      <= (or_all != '0);
  end

  // stage b: scale to the normalized bit length
  logic [2:0] [MW+NORM_BITS-1:0] wide;
  nmag_t [2:0] sh_next;
  ttb_ctl_t    b_ctl;
  nmag_t [2:0] b_mag;
  logic [2:0]  b_neg;
  logic        b_ok;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide[k] = {{NORM_BITS{1'b0}}, a_mag[k]};
      if (int'(a_bl) > NORM_BITS) begin
        wide[k] = wide[k] >> (int'(a_bl) - NORM_BITS);
      end else begin
        wide[k] = wide[k] << (NORM_BITS - int'(a_bl));
      end
      sh_next[k] = wide[k][NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl.vld <= 1'b0;
    end else begin
      b_ctl.vld <= a_ctl.vld;
    end
    b_ctl.tag <= a_ctl.tag;
    b_mag     <= sh_next;
    b_neg     <= a_neg;
    b_ok      <= a_ok;
  end

  // stage c: squares
  ttb_ctl_t    c_ctl;
  sq_t  [2:0]  c_sq;
  nmag_t [2:0] c_mag;
  logic [2:0]  c_neg;
  logic        c_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl.vld <= 1'b0;
    end else begin
      c_ctl.vld <= b_ctl.vld;
    end
    c_ctl.tag <= b_ctl.tag;
    for (int k = 0; k < 3; k++) begin
      c_sq[k] <= b_mag[k] * b_mag[k];
    end
    c_mag <= b_mag;
    c_neg <= b_neg;
    c_ok  <= b_ok;
  end

  // square root pipeline, one root bit per stage; entry 0 holds the sum
  ttb_ctl_t    q_ctl [0:SQS];
  logic [63:0] q_rem [0:SQS];
  root_t       q_root[0:SQS];
  nmag_t [2:0] q_mag [0:SQS];
  logic [2:0]  q_neg [0:SQS];
  logic        q_ok  [0:SQS];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ctl[0].vld <= 1'b0;
    end else begin
      q_ctl[0].vld <= c_ctl.vld;
    end
    q_ctl[0].tag <= c_ctl.tag;
    q_rem[0]     <= 64'(c_sq[0]) + 64'(c_sq[1]) + 64'(c_sq[2]);
    q_root[0]    <= '0;
    q_mag[0]     <= c_mag;
    q_neg[0]     <= c_neg;
    q_ok[0]      <= c_ok;
  end

  for (genvar s = 0; s < SQS; s++) begin : g_sqrt
    localparam int BIT = SQS - 1 - s;
    logic [63:0] cand;
    assign cand = ({{(64-ROOT_BITS){1'b0}}, q_root[s]} << (BIT + 1))
                  + (64'd1 << (2 * BIT));
    always_ff @(posedge clk) begin
      if (rst) begin
        q_ctl[s+1].vld <= 1'b0;
      end else begin
        q_ctl[s+1].vld <= q_ctl[s].vld;
      end
      q_ctl[s+1].tag <= q_ctl[s].tag;
      if (q_rem[s] >= cand) begin
        q_rem[s+1]  <= q_rem[s] - cand;
        q_root[s+1] <= q_root[s] | (root_t'(1) << BIT);
      end else begin
        q_rem[s+1]  <= q_rem[s];
        q_root[s+1] <= q_root[s];
      end
      q_mag[s+1] <= q_mag[s];
      q_neg[s+1] <= q_neg[s];
      q_ok[s+1]  <= q_ok[s];
    end
  end

  // division pipeline, one quotient bit per stage; entry 0 holds the rounded numerator
  ttb_ctl_t    d_ctl [0:DVS];
  drem_t [2:0] d_rem [0:DVS];
  quo_t  [2:0] d_quo [0:DVS];
  root_t       d_len [0:DVS];
  logic [2:0]  d_neg [0:DVS];
  logic        d_ok  [0:DVS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl[0].vld <= 1'b0;
    end else begin
      d_ctl[0].vld <= q_ctl[SQS].vld;
    end
    d_ctl[0].tag <= q_ctl[SQS].tag;
    for (int k = 0; k < 3; k++) begin
      d_rem[0][k] <= (drem_t'(q_mag[SQS][k]) << 14) + drem_t'(q_root[SQS] >> 1);
      d_quo[0][k] <= '0;
    end
    d_len[0] <= q_root[SQS];
    d_neg[0] <= q_neg[SQS];
    d_ok[0]  <= q_ok[SQS];
  end

  for (genvar t = 0; t < DVS; t++) begin : g_div
    localparam int BIT = DVS - 1 - t;
    drem_t dsub;
    assign dsub = drem_t'(d_len[t]) << BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        d_ctl[t+1].vld <= 1'b0;
      end else begin
        d_ctl[t+1].vld <= d_ctl[t].vld;
      end
      d_ctl[t+1].tag <= d_ctl[t].tag;
      for (int k = 0; k < 3; k++) begin
        if (d_rem[t][k] >= dsub) begin
          d_rem[t+1][k] <= d_rem[t][k] - dsub;
          d_quo[t+1][k] <= d_quo[t][k] | (quo_t'(1) << BIT);
        end else begin
          d_rem[t+1][k] <= d_rem[t][k];
          d_quo[t+1][k] <= d_quo[t][k];
        end
      end
      d_len[t+1] <= d_len[t];
      d_neg[t+1] <= d_neg[t];
      d_ok[t+1]  <= d_ok[t];
    end
  end

  // cap at one, apply sign and pack
  logic [47:0] vec_next;
  quo_t        capped;

  always_comb begin
    vec_next = '0;
    capped   = '0;
    for (int k = 0; k < 3; k++) begin
      capped = (d_quo[DVS][k] > quo_t'(ONE_Q14)) ? quo_t'(ONE_Q14) : d_quo[DVS][k];
      if (d_neg[DVS][k]) begin
        capped = quo_t'(-capped);
      end
      vec_next[k*OUT_BITS +: OUT_BITS] = capped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.vld <= 1'b0;
    end else begin
      out_ctl.vld <= d_ctl[DVS].vld;
    end
    out_ctl.tag <= d_ctl[DVS].tag;
    out_vec     <= vec_next;
    out_ok      <= d_ok[DVS];
  end

endmodule
`default_nettype wire

// ===== src/ttb_check.sv =====
// port-level checks for the tangent and bitangent block, bound to the top level
`default_nettype none
module ttb_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [47:0] tangent_vec,
  input wire logic [47:0] bitangent_vec,
  input wire logic        degenerate
);

  // the pipeline never refuses a word
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // no result word right after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  // a degenerate triangle gives zero vectors
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> tangent_vec == 48'd0 && bitangent_vec == 48'd0)
    else $error("degenerate word with nonzero vectors");

  // a usable triangle gives two nonzero unit vectors
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> tangent_vec != 48'd0 && bitangent_vec != 48'd0)
    else $error("zero vector without degenerate");

endmodule

bind triangle_tangent_bitangent ttb_check u_ttb_check (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .tangent_vec   (tangent_vec),
  .bitangent_vec (bitangent_vec),
  .degenerate    (degenerate)
);
`default_nettype wire
